@@ src/sppg_pkg.sv @@
// Shared types and constants for the step pulse position generator.
// No dependencies; used by sppg_step and step_pulse_position_generator.
package sppg_pkg;

  // Command codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_MOVE    = 2'd1,
    FUNC_STOP    = 2'd2,
    FUNC_DISABLE = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRESCALE      = 2'd0;
  localparam logic [1:0] CFG_PERIOD_RELOAD = 2'd1;
  localparam logic [1:0] CFG_DIRECTION     = 2'd2;

  localparam logic [15:0] PRESCALE_RST      = 16'd0;
  localparam logic [15:0] PERIOD_RELOAD_RST = 16'd59999;
  localparam logic        DIRECTION_RST     = 1'b0;

  // Configuration registers
  typedef struct packed {
    logic [15:0] prescale;
    logic [15:0] period_reload;
    logic        direction;
  } cfg_t;

  // Axis state
  typedef struct packed {
    logic [15:0] prescale_count;
    logic [15:0] period_count;
    logic [31:0] step_position;
    logic [31:0] goal_position;
    logic        running;
    logic        driver_enabled;
  } axis_t;

  // One result word
  typedef struct packed {
    logic        step_level;
    logic        enable_n;
    logic        moving;
    logic [31:0] position;
    logic        step_taken;
  } result_t;

endpackage

@@ src/step_pulse_position_generator.sv @@
// Top level of the step/direction pulse generator with position tracking.
// Depends on sppg_pkg and sppg_step.

// Takes one command word per clock (tick, move, stop, disable) while in_ready
// is high and returns one result word per command. A word passes an input
// register; once the result register is free, the command logic updates the axis
// state and loads the result register, setting out_valid; in_ready drops only
// while the result register is full and not being taken. The configuration port
// is always ready and writes take effect on the next command; write it only
// while idle.
module step_pulse_position_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_target,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_step_level,
  output logic        out_enable_n,
  output logic        out_moving,
  output logic [31:0] out_position,
  output logic        out_step_taken,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  sppg_pkg::cfg_t    cfg_r;
  sppg_pkg::axis_t   st_r;
  sppg_pkg::axis_t   st_nxt;
  sppg_pkg::result_t res_nxt;
  sppg_pkg::result_t res_r;

  logic        in_valid_r;
  logic [1:0]  func_r;
  logic [31:0] target_r;
  logic        out_valid_r;
  logic        advance;

  // Move a word into the result register when the slot is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prescale      <= sppg_pkg::PRESCALE_RST;
      cfg_r.period_reload <= sppg_pkg::PERIOD_RELOAD_RST;
      cfg_r.direction     <= sppg_pkg::DIRECTION_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sppg_pkg::CFG_PRESCALE:      cfg_r.prescale      <= cfg_data[15:0];
        sppg_pkg::CFG_PERIOD_RELOAD: cfg_r.period_reload <= cfg_data[15:0];
        sppg_pkg::CFG_DIRECTION:     cfg_r.direction     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r   <= in_func;
      target_r <= in_target;
    end
  end

  sppg_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .func   (func_r),
    .target (target_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Axis state, updated once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_level = res_r.step_level;
  assign out_enable_n   = res_r.enable_n;
  assign out_moving     = res_r.moving;
  assign out_position   = res_r.position;
  assign out_step_taken = res_r.step_taken;

endmodule

@@ src/sppg_step.sv @@
// Next-state and result logic for one command word of the step generator.
// Depends on sppg_pkg for the command, configuration, state and result types.
module sppg_step (
  input  sppg_pkg::cfg_t    cfg,
  input  sppg_pkg::axis_t   st,
  input  logic [1:0]        func,
  input  logic [31:0]       target,
  output sppg_pkg::axis_t   st_nxt,
  output sppg_pkg::result_t res
);

  logic took;
  logic [15:0] half_reload;

  // Apply one command to the axis state
  always_comb begin
    st_nxt = st;
    took   = 1'b0;
    case (sppg_pkg::func_t'(func))
      sppg_pkg::FUNC_TICK: begin
        if (st.running) begin
          if (st.prescale_count < cfg.prescale) begin
            st_nxt.prescale_count = st.prescale_count + 16'd1;
          end else begin
            st_nxt.prescale_count = '0;
            if (st.period_count < cfg.period_reload) begin
              st_nxt.period_count = st.period_count + 16'd1;
            end else begin
              // Period complete: advance position, stop on arrival
              st_nxt.period_count = '0;
              took = 1'b1;
              if (cfg.direction) begin
                st_nxt.step_position = st.step_position + 32'd1;
              end else begin
                st_nxt.step_position = st.step_position - 32'd1;
              end
              if (st_nxt.step_position == st.goal_position) begin
                st_nxt.running = 1'b0;
              end
            end
          end
        end
      end
      sppg_pkg::FUNC_MOVE: begin
        st_nxt.goal_position = target;
        if (st.step_position == target) begin
          st_nxt.running = 1'b0;
        end else begin
          st_nxt.running        = 1'b1;
          st_nxt.driver_enabled = 1'b1;
        end
      end
      sppg_pkg::FUNC_STOP: begin
        st_nxt.running = 1'b0;
      end
      default: begin
        st_nxt.driver_enabled = 1'b0;
      end
    endcase
  end

  // Build the result from the updated state
  assign half_reload = cfg.period_reload >> 1;

  always_comb begin
    res.step_level = st_nxt.running && (st_nxt.period_count < half_reload);
    res.enable_n   = ~st_nxt.driver_enabled;
    res.moving     = st_nxt.running;
    res.position   = st_nxt.step_position;
    res.step_taken = took;
  end

endmodule

@@ src/sppg_checker.sv @@
// Port-level checks for step_pulse_position_generator, attached by bind.
// Sees only the top-level ports; no package dependency.
module sppg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_step_level,
  input logic        out_moving,
  input logic        out_step_taken,
  input logic [31:0] out_position,
  input logic        cfg_ready
);

  // Hold the position, step level and step-taken flag of a stalled result word unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position)
      && $stable(out_step_level) && $stable(out_step_taken))
    else $error("result word changed while stalled");

  // Pulse only while moving
  a_level_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_level |-> out_moving)
    else $error("step level high while not moving");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input side never blocks while output drains freely
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready && cfg_ready)
    else $error("input stalled with output ready");

endmodule

bind step_pulse_position_generator sppg_checker u_sppg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_step_level (out_step_level),
  .out_moving     (out_moving),
  .out_step_taken (out_step_taken),
  .out_position   (out_position),
  .cfg_ready      (cfg_ready)
);
